// ----- sv/assert_macros.svh -----
// Assertion macros shared by the segment crossing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define SIP_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SIP_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/sip_pkg.sv -----
// Types and constants of the segment crossing pipeline.
`timescale 1ns / 1ps

package sip_pkg;

    localparam int COORD_BITS = 16;
    // differences of two coordinates
    localparam int DW = COORD_BITS + 1;
    // products of two differences
    localparam int PW = 2 * COORD_BITS + 2;
    // denominator and line parameter
    localparam int NW = 2 * COORD_BITS + 3;
    // coordinate times denominator
    localparam int BW = COORD_BITS + NW;
    // line parameter times difference
    localparam int TW = NW + DW;
    // scaled crossing numerators
    localparam int XW = 3 * COORD_BITS + 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [NW-1:0]         den_t;
    typedef logic signed [BW-1:0]         bnd_t;
    typedef logic signed [TW-1:0]         tx_t;
    typedef logic signed [XW-1:0]         wide_t;

    // Input word: two segments AB and CD
    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t b_x;
        coord_t b_y;
        coord_t c_x;
        coord_t c_y;
        coord_t d_x;
        coord_t d_y;
    } sip_in_t;

    // Output word: crossing point
    typedef struct packed {
        logic   hit;
        coord_t cross_x;
        coord_t cross_y;
    } sip_out_t;

    // Which crossing rule applies
    typedef enum logic [1:0] {
        K_GEN = 2'd0,
        K_VAB = 2'd1,
        K_VCD = 2'd2,
        K_PT  = 2'd3
    } kind_t;

    // Front end to bounds stage: crossing as rational with nonnegative denominator
    typedef struct packed {
        logic    miss;
        kind_t   kind;
        sip_in_t pt;
        diff_t   ex;
        diff_t   ey;
        den_t    den;
        den_t    t;
    } fr_t;

    // Bounds stage to divider
    typedef struct packed {
        logic  hit;
        den_t  den;
        wide_t nx;
        wide_t ny;
    } sp_t;

endpackage

// ----- sv/sip_front.sv -----
// Front end: rule selection, products and signed denominator of the crossing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sip_front
    import sip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    seg_valid,
    input  sip_in_t seg_word,
    output logic    fr_valid,
    output fr_t     fr
);

    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = seg_word.a_x;
    assign ay = seg_word.a_y;
    assign bx = seg_word.b_x;
    assign by = seg_word.b_y;
    assign cx = seg_word.c_x;
    assign cy = seg_word.c_y;
    assign dx = seg_word.d_x;
    assign dy = seg_word.d_y;

    // ---- stage 1: differences and rule ----
    logic    v1_reg, miss1_reg, miss1_next;
    kind_t   kind1_reg, kind1_next;
    sip_in_t pt1_reg;
    diff_t   ex1_reg, ey1_reg, fx1_reg, fy1_reg, gx1_reg, gy1_reg;

    always_comb
    begin
        miss1_next = 1'b0;
        priority if (ax == bx)
        begin
            kind1_next = K_VAB;
            miss1_next = (cx == dx);
        end
        else if (cx == dx)
            kind1_next = K_VCD;
        else if ((ax == cx && ay == cy) || (ax == dx && ay == dy))
            kind1_next = K_PT;
        else
            kind1_next = K_GEN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss1_reg <= miss1_next;
            kind1_reg <= kind1_next;
            pt1_reg   <= seg_word;
            ex1_reg   <= diff_t'(bx) - diff_t'(ax);
            ey1_reg   <= diff_t'(by) - diff_t'(ay);
            fx1_reg   <= diff_t'(dx) - diff_t'(cx);
            fy1_reg   <= diff_t'(dy) - diff_t'(cy);
            gx1_reg   <= diff_t'(cx) - diff_t'(ax);
            gy1_reg   <= diff_t'(cy) - diff_t'(ay);
        end
    end

    // ---- stage 2: cross products ----
    logic    v2_reg, miss2_reg;
    kind_t   kind2_reg;
    sip_in_t pt2_reg;
    diff_t   ex2_reg, ey2_reg, fx2_reg;
    prod_t   p_exfy_reg, p_eyfx_reg, p_gxfy_reg, p_gyfx_reg;
    prod_t   p_cyfx_reg, p_ayex_reg, p_eygx_reg;
    coord_t  cy1, ay1;

    assign cy1 = pt1_reg.c_y;
    assign ay1 = pt1_reg.a_y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss2_reg  <= miss1_reg;
            kind2_reg  <= kind1_reg;
            pt2_reg    <= pt1_reg;
            ex2_reg    <= ex1_reg;
            ey2_reg    <= ey1_reg;
            fx2_reg    <= fx1_reg;
            p_exfy_reg <= prod_t'(ex1_reg) * prod_t'(fy1_reg);
            p_eyfx_reg <= prod_t'(ey1_reg) * prod_t'(fx1_reg);
            p_gxfy_reg <= prod_t'(gx1_reg) * prod_t'(fy1_reg);
            p_gyfx_reg <= prod_t'(gy1_reg) * prod_t'(fx1_reg);
            p_cyfx_reg <= prod_t'(cy1) * prod_t'(fx1_reg);
            p_ayex_reg <= prod_t'(ay1) * prod_t'(ex1_reg);
            p_eygx_reg <= prod_t'(ey1_reg) * prod_t'(gx1_reg);
        end
    end

    // ---- stage 3: raw denominator and numerator per rule ----
    logic    v3_reg, miss3_reg;
    kind_t   kind3_reg;
    sip_in_t pt3_reg;
    diff_t   ex3_reg, ey3_reg;
    den_t    den3_reg, den3_next, t3_reg, t3_next;

    always_comb
    begin
        den3_next = den_t'(1);
        t3_next   = den_t'(0);
        unique case (kind2_reg)
            K_GEN:
            begin
                den3_next = den_t'(p_exfy_reg) - den_t'(p_eyfx_reg);
                t3_next   = den_t'(p_gxfy_reg) - den_t'(p_gyfx_reg);
            end
            K_VAB:
            begin
                den3_next = den_t'(fx2_reg);
                t3_next   = den_t'(p_cyfx_reg) - den_t'(p_gxfy_reg);
            end
            K_VCD:
            begin
                den3_next = den_t'(ex2_reg);
                t3_next   = den_t'(p_ayex_reg) + den_t'(p_eygx_reg);
            end
            K_PT:
            begin
                den3_next = den_t'(1);
                t3_next   = den_t'(0);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss3_reg <= miss2_reg;
            kind3_reg <= kind2_reg;
            pt3_reg   <= pt2_reg;
            ex3_reg   <= ex2_reg;
            ey3_reg   <= ey2_reg;
            den3_reg  <= den3_next;
            t3_reg    <= t3_next;
        end
    end

    // ---- stage 4: make the denominator nonnegative ----
    logic v4_reg;
    fr_t  fr_reg, fr_next;

    always_comb
    begin
        fr_next.miss = miss3_reg | (kind3_reg == K_GEN && den3_reg == den_t'(0));
        fr_next.kind = kind3_reg;
        fr_next.pt   = pt3_reg;
        fr_next.ex   = ex3_reg;
        fr_next.ey   = ey3_reg;
        fr_next.den  = den3_reg[NW-1] ? -den3_reg : den3_reg;
        fr_next.t    = den3_reg[NW-1] ? -t3_reg : t3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fr_reg <= fr_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= seg_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign fr_valid = v4_reg;
    assign fr       = fr_reg;

    // checks
    `SIP_IMPLIES(a_den_nonneg, fr_valid, !fr.den[NW-1], "denominator left negative")
    `SIP_IMPLIES(a_pt_den_one, fr_valid && fr.kind == K_PT, fr.den == den_t'(1), "shared point den not one")

endmodule

// ----- sv/sip_span.sv -----
// Bounds stage: scaled crossing numerators and bounding box test.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sip_span
    import sip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic fr_valid,
    input  fr_t  fr,
    output logic sp_valid,
    output sp_t  sp
);

    // a crossing strictly on one side of both ends of a span is outside
    function automatic logic span_out(wide_t n, wide_t p, wide_t q);
        return (n < p && n < q) || (n > p && n > q);
    endfunction

    den_t   den_in, t_in;
    diff_t  ex_in, ey_in;
    coord_t cv [8];

    assign den_in = fr.den;
    assign t_in   = fr.t;
    assign ex_in  = fr.ex;
    assign ey_in  = fr.ey;
    assign cv[0]  = fr.pt.a_x;
    assign cv[1]  = fr.pt.b_x;
    assign cv[2]  = fr.pt.c_x;
    assign cv[3]  = fr.pt.d_x;
    assign cv[4]  = fr.pt.a_y;
    assign cv[5]  = fr.pt.b_y;
    assign cv[6]  = fr.pt.c_y;
    assign cv[7]  = fr.pt.d_y;

    // ---- stage 1: every endpoint coordinate scaled by the denominator ----
    logic  v1_reg, miss1_reg;
    kind_t kind1_reg;
    bnd_t  bnd1_reg [8];
    tx_t   tex1_reg, tey1_reg;
    den_t  den1_reg, t1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
                bnd1_reg[i] <= bnd_t'(cv[i]) * bnd_t'(den_in);
            tex1_reg  <= tx_t'(t_in) * tx_t'(ex_in);
            tey1_reg  <= tx_t'(t_in) * tx_t'(ey_in);
            den1_reg  <= den_in;
            t1_reg    <= t_in;
            kind1_reg <= fr.kind;
            miss1_reg <= fr.miss;
        end
    end

    // ---- stage 2: crossing numerators over the common denominator ----
    logic  v2_reg, miss2_reg;
    bnd_t  bnd2_reg [8];
    den_t  den2_reg;
    wide_t nx2_reg, nx2_next, ny2_reg, ny2_next;
    wide_t x_base;

    assign x_base = (kind1_reg == K_VCD) ? wide_t'(bnd1_reg[2]) : wide_t'(bnd1_reg[0]);

    always_comb
    begin
        nx2_next = x_base;
        ny2_next = wide_t'(t1_reg);
        unique case (kind1_reg)
            K_GEN:
            begin
                nx2_next = x_base + wide_t'(tex1_reg);
                ny2_next = wide_t'(bnd1_reg[4]) + wide_t'(tey1_reg);
            end
            K_PT:
                ny2_next = wide_t'(bnd1_reg[4]);
            K_VAB, K_VCD:
                ny2_next = wide_t'(t1_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
                bnd2_reg[i] <= bnd1_reg[i];
            nx2_reg   <= nx2_next;
            ny2_reg   <= ny2_next;
            den2_reg  <= den1_reg;
            miss2_reg <= miss1_reg;
        end
    end

    // ---- stage 3: bounding box test on the exact crossing ----
    logic v3_reg;
    sp_t  sp_reg, sp_next;
    logic outside;

    always_comb
    begin
        outside = span_out(nx2_reg, wide_t'(bnd2_reg[0]), wide_t'(bnd2_reg[1]))
               || span_out(nx2_reg, wide_t'(bnd2_reg[2]), wide_t'(bnd2_reg[3]))
               || span_out(ny2_reg, wide_t'(bnd2_reg[4]), wide_t'(bnd2_reg[5]))
               || span_out(ny2_reg, wide_t'(bnd2_reg[6]), wide_t'(bnd2_reg[7]));
        sp_next.hit = !miss2_reg && !outside;
        sp_next.den = den2_reg;
        sp_next.nx  = nx2_reg;
        sp_next.ny  = ny2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sp_reg <= sp_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= fr_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign sp_valid = v3_reg;
    assign sp       = sp_reg;

    // checks
    `SIP_IMPLIES(a_hit_den, sp_valid && sp.hit, sp.den != den_t'(0), "hit with zero denominator")

endmodule

// ----- sv/sip_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for both coordinates.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sip_div
    import sip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     sp_valid,
    input  sp_t      sp,
    output logic     pt_valid,
    output sip_out_t pt_word
);

    localparam int QB = COORD_BITS;

    typedef logic [XW-1:0] rem_t;
    typedef logic [QB-1:0] quo_t;
    typedef logic [NW-1:0] dvs_t;

    wide_t nx_in, ny_in;
    assign nx_in = sp.nx;
    assign ny_in = sp.ny;

    // stage arrays, index 0 holds the magnitudes
    logic v_reg   [QB+1];
    logic hit_reg [QB+1];
    logic negx_reg[QB+1];
    logic negy_reg[QB+1];
    dvs_t dv_reg  [QB+1];
    rem_t rx_reg  [QB+1];
    rem_t ry_reg  [QB+1];
    quo_t qx_reg  [QB+1];
    quo_t qy_reg  [QB+1];

    // ---- stage 0: magnitudes and signs ----
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg[0]  <= sp.hit;
            negx_reg[0] <= nx_in[XW-1];
            negy_reg[0] <= ny_in[XW-1];
            dv_reg[0]   <= dvs_t'(sp.den);
            rx_reg[0]   <= nx_in[XW-1] ? rem_t'(-nx_in) : rem_t'(nx_in);
            ry_reg[0]   <= ny_in[XW-1] ? rem_t'(-ny_in) : rem_t'(ny_in);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= sp_valid;
    end

    // ---- bit stages, most significant quotient bit first ----
    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        localparam int SH = QB - 1 - k;
        rem_t dsh;
        logic ge_x, ge_y;

        assign dsh  = rem_t'(dv_reg[k]) << SH;
        assign ge_x = rx_reg[k] >= dsh;
        assign ge_y = ry_reg[k] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hit_reg[k+1]  <= hit_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                dv_reg[k+1]   <= dv_reg[k];
                rx_reg[k+1]   <= ge_x ? rx_reg[k] - dsh : rx_reg[k];
                ry_reg[k+1]   <= ge_y ? ry_reg[k] - dsh : ry_reg[k];
                qx_reg[k+1]   <= {qx_reg[k][QB-2:0], ge_x};
                qy_reg[k+1]   <= {qy_reg[k][QB-2:0], ge_y};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end
    end

    // ---- output register: sign back on, miss forces minus one ----
    logic     vo_reg;
    sip_out_t word_reg, word_next;
    quo_t     qx_f, qy_f;

    assign qx_f = qx_reg[QB];
    assign qy_f = qy_reg[QB];

    always_comb
    begin
        word_next.hit     = hit_reg[QB];
        word_next.cross_x = '1;
        word_next.cross_y = '1;
        if (hit_reg[QB])
        begin
            word_next.cross_x = coord_t'(negx_reg[QB] ? -qx_f : qx_f);
            word_next.cross_y = coord_t'(negy_reg[QB] ? -qy_f : qy_f);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[QB];
    end

    assign pt_valid = vo_reg;
    assign pt_word  = word_reg;

    // checks
    `SIP_IMPLIES(a_miss_ones, pt_valid && !pt_word.hit, pt_word.cross_x == '1 && pt_word.cross_y == '1, "miss word without minus one")

endmodule

// ----- sv/segment_intersection_point.sv -----
// Throughput: one word per cycle unless the output word is stalled; front end, bounds stage
// and divider are fully pipelined.
// The divider resolves one quotient bit per stage, which sets most of the latency.
// A stalled output word freezes the whole pipeline; input stall follows at once.
// Reset clears the valid bits only; no result is in flight afterwards.
`timescale 1ns / 1ps

module segment_intersection_point
    import sip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     seg_valid,
    output logic     seg_stall,
    input  sip_in_t  seg_word,
    output logic     pt_valid,
    input  logic     pt_stall,
    output sip_out_t pt_word
);

    logic en;
    logic fr_valid, sp_valid;
    fr_t  fr;
    sp_t  sp;

    // pipeline advances unless the output word is held
    assign en        = !(pt_valid && pt_stall);
    assign seg_stall = !en;

    sip_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .seg_valid(seg_valid),
        .seg_word (seg_word),
        .fr_valid (fr_valid),
        .fr       (fr)
    );

    sip_span u_span (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .fr_valid(fr_valid),
        .fr      (fr),
        .sp_valid(sp_valid),
        .sp      (sp)
    );

    sip_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sp_valid(sp_valid),
        .sp      (sp),
        .pt_valid(pt_valid),
        .pt_word (pt_word)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the segment crossing pipeline.
`timescale 1ns / 1ps

module tb;
    import sip_pkg::*;

    localparam int LATENCY     = 7 + COORD_BITS + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     seg_valid;
    logic     seg_stall;
    sip_in_t  seg_word;
    logic     pt_valid;
    logic     pt_stall;
    sip_out_t pt_word;

    segment_intersection_point uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg_word  (seg_word),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt_word   (pt_word)
    );

    sip_in_t  pending_segs[$];
    sip_out_t expected_pts[$];
    int       fail_count;
    int       cycle_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       recv_hold;
    bit       send_pause;
    bit       seg_accepted;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact crossing of two segments; miss gives hit = 0 at (-1,-1).
    function automatic sip_out_t crossing_point(input sip_in_t s);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint ex, ey, fx, fy;
        logic signed [127:0] nx, ny, dn, den, t;
        logic signed [127:0] qx, qy;
        bit ok;
        sip_out_t r;
        ax = s.a_x; ay = s.a_y; bx = s.b_x; by = s.b_y;
        cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
        ok = 1'b1;
        nx = 0; ny = 0; dn = 1;
        if (ax == bx)
        begin
            if (cx == dx)
                ok = 1'b0;
            else
            begin
                nx = ax;
                ny = 128'(cy) * (cx - dx) + 128'(cy - dy) * (ax - cx);
                dn = cx - dx;
                nx = nx * dn;
            end
        end
        else if (cx == dx)
        begin
            dn = ax - bx;
            nx = 128'(cx) * dn;
            ny = 128'(ay) * (ax - bx) + 128'(ay - by) * (cx - ax);
        end
        else if ((ax == cx && ay == cy) || (ax == dx && ay == dy))
        begin
            nx = ax;
            ny = ay;
        end
        else
        begin
            ex = bx - ax; ey = by - ay; fx = dx - cx; fy = dy - cy;
            den = 128'(ex) * fy - 128'(ey) * fx;
            if (den == 0)
                ok = 1'b0;
            else
            begin
                t  = 128'(cx - ax) * fy - 128'(cy - ay) * fx;
                nx = 128'(ax) * den + t * ex;
                ny = 128'(ay) * den + t * ey;
                dn = den;
            end
        end
        // normalize to a positive denominator
        if (dn < 0)
        begin
            nx = -nx; ny = -ny; dn = -dn;
        end
        // bounds on the exact value, edges inside
        if (ok)
        begin
            if ((nx < ax * dn && nx < bx * dn) || (nx > ax * dn && nx > bx * dn) ||
                (nx < cx * dn && nx < dx * dn) || (nx > cx * dn && nx > dx * dn) ||
                (ny < ay * dn && ny < by * dn) || (ny > ay * dn && ny > by * dn) ||
                (ny < cy * dn && ny < dy * dn) || (ny > cy * dn && ny > dy * dn))
                ok = 1'b0;
        end
        if (ok)
        begin
            qx = nx / dn;  // truncates toward zero
            qy = ny / dn;
            r.hit = 1'b1;
            r.cross_x = qx[COORD_BITS-1:0];
            r.cross_y = qy[COORD_BITS-1:0];
        end
        else
        begin
            r.hit = 1'b0;
            r.cross_x = '1;
            r.cross_y = '1;
        end
        return r;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 5) == 0 ? 16'h8000 : 16'h7fff);
            1: return coord_t'(int'($urandom_range(0, 20)) - 10);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic sip_in_t rand_seg();
        sip_in_t s;
        int mode;
        s = sip_in_t'({$urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(0, 9);
        if (mode < 3)
        begin
            // small box: many real crossings
            s.a_x = rand_coord() >>> 4; s.a_y = $signed(s.a_y) >>> 6;
            s.b_x = $signed(s.b_x) >>> 6; s.b_y = $signed(s.b_y) >>> 6;
            s.c_x = $signed(s.c_x) >>> 6; s.c_y = $signed(s.c_y) >>> 6;
            s.d_x = $signed(s.d_x) >>> 6; s.d_y = $signed(s.d_y) >>> 6;
        end
        else if (mode == 3)
            s.b_x = s.a_x;
        else if (mode == 4)
            s.d_x = s.c_x;
        else if (mode == 5)
        begin
            s.c_x = s.a_x; s.c_y = s.a_y;
        end
        else if (mode == 6)
        begin
            s.d_x = s.a_x; s.d_y = s.a_y;
        end
        else if (mode == 7)
        begin
            // parallel: CD is AB shifted
            s.c_x = coord_t'(s.a_x + 3); s.c_y = s.a_y;
            s.d_x = coord_t'(s.b_x + 3); s.d_y = s.b_y;
        end
        else if (mode == 8)
        begin
            s.a_x = rand_coord(); s.b_y = rand_coord(); s.d_x = rand_coord();
        end
        return s;
    endfunction

    function automatic sip_in_t mk_seg(input int ax, ay, bx, by, cx, cy, dx, dy);
        sip_in_t s;
        s.a_x = coord_t'(ax); s.a_y = coord_t'(ay);
        s.b_x = coord_t'(bx); s.b_y = coord_t'(by);
        s.c_x = coord_t'(cx); s.c_y = coord_t'(cy);
        s.d_x = coord_t'(dx); s.d_y = coord_t'(dy);
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_segs.size() != 0 || expected_pts.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus and phase control
    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 53;
        recv_hold = 0;
        send_pause = 1'b0;
        fail_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes and each crossing rule
        pending_segs.push_back(mk_seg(0, 0, 10, 10, 0, 10, 10, 0));
        pending_segs.push_back(mk_seg(5, -5, 5, 5, -3, 0, 8, 1));
        pending_segs.push_back(mk_seg(5, -5, 5, 5, 7, -5, 7, 5));
        pending_segs.push_back(mk_seg(-4, 0, 4, 3, 1, -9, 1, 9));
        pending_segs.push_back(mk_seg(2, 3, 9, 1, 2, 3, -5, 7));
        pending_segs.push_back(mk_seg(2, 3, 9, 1, -5, 7, 2, 3));
        pending_segs.push_back(mk_seg(0, 0, 4, 4, 1, 1, 6, 6));
        pending_segs.push_back(mk_seg(0, 0, 4, 4, 0, 1, 4, 5));
        pending_segs.push_back(mk_seg(0, 0, 2, 2, 10, 0, 9, 1));
        pending_segs.push_back(mk_seg(-2, 0, 0, -2, -2, -2, 0, 0));
        pending_segs.push_back(mk_seg(-3, -1, 1, -1, -1, -4, -1, 2));
        pending_segs.push_back(mk_seg(0, 0, 3, 1, 0, 1, 3, 0));
        pending_segs.push_back(mk_seg(-1, 0, -2, 1, -2, 0, -1, 1));
        pending_segs.push_back(mk_seg(3, 3, 3, 3, 3, 3, 5, 5));
        pending_segs.push_back(mk_seg(3, 3, 3, 3, 1, 1, 5, 5));
        pending_segs.push_back(mk_seg(-32768, -32768, 32767, 32767,
                                      -32768, 32767, 32767, -32768));
        pending_segs.push_back(mk_seg(32767, -32768, -32768, 32767,
                                      -32768, -32768, 32767, 32767));
        pending_segs.push_back(mk_seg(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        pending_segs.push_back(mk_seg(-32768, -32768, -32768, 32767,
                                      32767, 32767, -32768, 0));
        pending_segs.push_back(mk_seg(32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768));
        pending_segs.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0));
        pending_segs.push_back(mk_seg(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_segs.push_back(sip_in_t'('0));
        wait_drained();

        // phase 1: sender rarely idles, receiver often
        for (int i = 0; i < 600; i++)
            pending_segs.push_back(rand_seg());
        // long receiver hold-off while items keep coming
        recv_hold = 200;
        wait_drained();

        // swap idling
        send_idle_pct = 53;
        recv_idle_pct = 8;
        for (int i = 0; i < 650; i++)
            pending_segs.push_back(rand_seg());
        // sender pauses with results in flight until every one has come back
        while (expected_pts.size() < 5)
            @(posedge clk);
        send_pause = 1'b1;
        while (expected_pts.size() != 0)
            @(posedge clk);
        send_pause = 1'b0;
        wait_drained();

        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 700; i++)
            pending_segs.push_back(rand_seg());
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0)
            $display("segment_intersection_point verification clean");
        else
            $display("segment_intersection_point verification failed");
        $finish;
    end

    // Driver: changes on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid <= 1'b0;
            seg_word  <= '0;
        end
        else if (!seg_valid || seg_accepted)
        begin
            if (pending_segs.size() != 0 && !send_pause &&
                $urandom_range(1, 100) > send_idle_pct)
            begin
                seg_valid <= 1'b1;
                seg_word  <= pending_segs[0];
            end
            else
                seg_valid <= 1'b0;
        end
    end

    // Receiver stall: random, or held off for a counted stretch
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_stall <= 1'b0;
        else if (recv_hold > 0)
        begin
            pt_stall  <= 1'b1;
            recv_hold <= recv_hold - 1;
        end
        else
            pt_stall <= ($urandom_range(1, 100) <= recv_idle_pct);
    end

    // Monitor: input acceptance and output checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count  <= cycle_count + 1;
            seg_accepted <= seg_valid && !seg_stall;
            if (seg_valid && !seg_stall)
            begin
                expected_pts.push_back(crossing_point(seg_word));
                void'(pending_segs.pop_front());
            end
            if (pt_valid && !pt_stall)
            begin
                if (expected_pts.size() == 0)
                begin
                    $error("unexpected output word %h", pt_word);
                    fail_count++;
                end
                else
                begin
                    sip_out_t e;
                    e = expected_pts.pop_front();
                    if (pt_word.hit !== e.hit)
                    begin
                        $error("hit: expected %0d, got %0d", e.hit, pt_word.hit);
                        fail_count++;
                    end
                    if (pt_word.cross_x !== e.cross_x)
                    begin
                        $error("cross_x: expected %0d, got %0d", e.cross_x, pt_word.cross_x);
                        fail_count++;
                    end
                    if (pt_word.cross_y !== e.cross_y)
                    begin
                        $error("cross_y: expected %0d, got %0d", e.cross_y, pt_word.cross_y);
                        fail_count++;
                    end
                end
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("segment_intersection_point verification failed");
                $finish;
            end
        end
        else
        begin
            cycle_count  <= 0;
            seg_accepted <= 1'b0;
        end
    end

endmodule
